FILE: rtl/rsxb_pkg.sv
// Shared constants, types and helpers of the x*exp(x) root solver.
`default_nettype none
package rsxb_pkg;

   localparam int FRAC_BITS   = 40;
   localparam int X_W         = 42;
   localparam int TGT_W       = 46;
   localparam int TOL_W       = 41;
   localparam int STEP_W      = 7;
   localparam int K_W         = 6;
   localparam int NUM_W       = 104;

   localparam logic [6:0]  MAX_STEPS    = 7'd64;
   localparam logic [5:0]  SERIES_TERMS = 6'd40;
   localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;
   localparam logic [63:0] SAT_CAP  = 64'd1 << 60;
   localparam logic [63:0] DX_START = 64'd1000 << FRAC_BITS;
   localparam logic [X_W-1:0] XMAX  = {X_W{1'b1}};

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOSIGN    = 2'd1;
   localparam logic [1:0] ST_ZERODERIV = 2'd2;
   localparam logic [1:0] ST_LIMIT     = 2'd3;

   localparam logic [2:0] CFG_METHOD = 3'd0;
   localparam logic [2:0] CFG_TARGET = 3'd1;
   localparam logic [2:0] CFG_LOWER  = 3'd2;
   localparam logic [2:0] CFG_UPPER  = 3'd3;
   localparam logic [2:0] CFG_START  = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE, S_EV_START, S_SER_INIT, S_SER_MUL, S_SER_MULW, S_SER_DIVW,
      S_POW_CHK, S_POW_MULW, S_PROD_MULW,
      S_R_BLO, S_R_BHI, S_B_CHK, S_R_BMID,
      S_R_NFIRST, S_N_CHK, S_R_NEV, S_N_DIVW, S_DONE
   } state_type;

   // Sign code: bit 1 negative, bit 0 positive, both clear for zero.
   typedef logic [1:0] sign_type;

   function automatic sign_type sign_of(input logic [64:0] f);
      return {f[64], (f != 65'd0) && !f[64]};
   endfunction

   function automatic logic same_sign(input sign_type a, input sign_type b);
      return (a[0] && b[0]) || (a[1] && b[1]);
   endfunction

   function automatic logic opposite_sign(input sign_type a, input sign_type b);
      return (a[0] && b[1]) || (a[1] && b[0]);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rsxb_mul.sv
// Multi-cycle saturating fixed-point multiplier, 16 bits of b per cycle.
`default_nettype none
module rsxb_mul
   import rsxb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [63:0]      result
);

   logic [63:0]  a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [15:0]  chunk;
   logic [79:0]  prod;
   logic [127:0] part;
   logic [63:0]  raw;

   always_comb begin
      chunk = 16'(b_ff >> {cnt_ff[1:0], 4'b0000});
      prod  = a_ff * {64'd0, chunk};
      part  = {48'd0, prod} << {cnt_ff[1:0], 4'b0000};
      raw   = acc_ff[103:40];
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0; res_in = res_ff;
      if (start) begin
         a_in = a; b_in = b; acc_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (acc_ff[127:104] != 24'd0 || raw > SAT_CAP) res_in = SAT_CAP;
            else res_in = raw;
         end else begin
            acc_in = acc_ff + part;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in; res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

FILE: rtl/rsxb_div.sv
// Restoring divider, one quotient bit per cycle, 104-bit dividend.
`default_nettype none
module rsxb_div
   import rsxb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [63:0]      den,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   logic [NUM_W-1:0] num_ff, num_in, q_ff, q_in;
   logic [64:0]      rem_ff, rem_in, trial;
   logic [63:0]      den_ff, den_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial = {rem_ff[63:0], num_ff[NUM_W-1]};
      num_in = num_ff; q_in = q_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         num_in = num; den_in = den; rem_in = '0; q_in = '0;
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in; q_ff <= q_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

FILE: rtl/root_solver_xexp_bisect_newton.sv
// Top level: sequencer of the x*exp(x) root solver around a shared multiplier and divider.
//
//  channel | direction | beat contents
//  req     | in        | tdata[40:0] tolerance
//  rsp     | out       | tdata[41:0] root, tdata[48:42] step_count; tuser[1:0] status
//  csr     | in        | csr_index register number, csr_data value
//
// Every evaluation of x*exp(x) runs two Taylor series of up to 40 terms, each term a
// multiply and a divide, and each Newton step adds one divide.
// req_tready is high only while idle; the result waits in rsp until taken.
// Reset is synchronous and restores the default register values.
`default_nettype none
module root_solver_xexp_bisect_newton
   import rsxb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // tolerance[40:0], zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // root[41:0], step_count[48:42], zero fill
   output logic [1:0]       rsp_tuser,   // status[1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [45:0] csr_data
);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic             method_ff;
   logic [TGT_W-1:0] target_ff;
   logic [X_W-1:0]   lower_ff, upper_ff, start_ff;
   logic [TOL_W-1:0] tol_ff, tol_in;
   logic [X_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, x_ff, x_in;
   logic [X_W-1:0]   ex_x_ff, ex_x_in, root_ff, root_in;
   logic [63:0]      dx_ff, dx_in, r_ff, r_in, sum_ff, sum_in, term_ff, term_in;
   logic [63:0]      v_ff, v_in, e_ff, e_in, d_ff, d_in;
   logic [64:0]      f_ff, f_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic             exp_sel_ff, exp_sel_in;
   logic [1:0]       pow_ff, pow_in, status_ff, status_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   sign_type         sl_ff, sl_in, sh_ff, sh_in, sm;

   logic             mul_start, mul_done, div_start, div_done;
   logic [63:0]      mul_a, mul_b, mul_res, div_den, q, sum_new, ser_final, fmag;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [X_W-1:0]   span, xn;
   logic [64:0]      xsum;

   rsxb_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .result(mul_res)
   );

   rsxb_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_quot)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= 1'b0;
         target_ff <= 46'd10786208068483;
         lower_ff  <= 42'd1099511627776;
         upper_ff  <= 42'd2199023255552;
         start_ff  <= 42'd1649267441664;
      end else if (csr_valid) begin
         unique case (csr_index)
            CFG_METHOD: method_ff <= csr_data[0];
            CFG_TARGET: target_ff <= csr_data;
            CFG_LOWER:  lower_ff  <= csr_data[X_W-1:0];
            CFG_UPPER:  upper_ff  <= csr_data[X_W-1:0];
            CFG_START:  start_ff  <= csr_data[X_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; tol_in = tol_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff; x_in = x_ff;
      ex_x_in = ex_x_ff; root_in = root_ff; dx_in = dx_ff; r_in = r_ff;
      sum_in = sum_ff; term_in = term_ff; v_in = v_ff; e_in = e_ff;
      d_in = d_ff; f_in = f_ff; k_in = k_ff; exp_sel_in = exp_sel_ff;
      pow_in = pow_ff; status_in = status_ff; steps_in = steps_ff;
      sl_in = sl_ff; sh_in = sh_ff;
      mul_start = 1'b0; mul_a = term_ff; mul_b = r_ff;
      div_start = 1'b0; div_num = {40'd0, mul_res}; div_den = {58'd0, k_ff};

      sm        = sign_of(f_ff);
      q         = div_quot[63:0];
      sum_new   = sum_ff + q;
      ser_final = (q == 64'd0) ? sum_ff : sum_new;
      span      = hi_ff - lo_ff;
      fmag      = f_ff[64] ? 64'(-f_ff) : f_ff[63:0];
      if (div_quot[NUM_W-1:61] != '0) q = SAT_CAP;
      xsum      = {23'd0, x_ff} + {1'b0, q};
      if (sm[0]) xn = ({22'd0, x_ff} >= q) ? x_ff - q[X_W-1:0] : '0;
      else       xn = (xsum > {23'd0, XMAX}) ? XMAX : xsum[X_W-1:0];
      if (state_ff == S_SER_DIVW) q = div_quot[63:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               tol_in = req_tdata[TOL_W-1:0];
               steps_in = '0;
               status_in = ST_OK;
               state_in = S_EV_START;
               if (!method_ff) begin
                  lo_in = (lower_ff > upper_ff) ? upper_ff : lower_ff;
                  hi_in = (lower_ff > upper_ff) ? lower_ff : upper_ff;
                  ex_x_in = (lower_ff > upper_ff) ? upper_ff : lower_ff;
                  ret_in = S_R_BLO;
               end else begin
                  x_in = start_ff;
                  ex_x_in = start_ff;
                  dx_in = DX_START;
                  ret_in = S_R_NFIRST;
               end
            end
         end
         S_EV_START: begin
            r_in = {24'd0, ex_x_ff[FRAC_BITS-1:0]};
            exp_sel_in = 1'b0;
            state_in = S_SER_INIT;
         end
         S_SER_INIT: begin
            sum_in = ONE;
            term_in = ONE;
            k_in = 6'd1;
            state_in = S_SER_MUL;
         end
         S_SER_MUL: begin
            mul_start = 1'b1;
            state_in = S_SER_MULW;
         end
         S_SER_MULW: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in = S_SER_DIVW;
            end
         end
         S_SER_DIVW: begin
            if (div_done) begin
               if (q != 64'd0 && k_ff != SERIES_TERMS) begin
                  sum_in = sum_new;
                  term_in = q;
                  k_in = k_ff + 6'd1;
                  state_in = S_SER_MUL;
               end else if (!exp_sel_ff) begin
                  // Fraction series done; now the same series at 1.0 gives e.
                  v_in = ser_final;
                  exp_sel_in = 1'b1;
                  r_in = ONE;
                  state_in = S_SER_INIT;
               end else begin
                  e_in = ser_final;
                  pow_in = ex_x_ff[X_W-1:FRAC_BITS];
                  state_in = S_POW_CHK;
               end
            end
         end
         S_POW_CHK: begin
            mul_start = 1'b1;
            if (pow_ff == 2'd0) begin
               mul_a = {22'd0, ex_x_ff};
               mul_b = v_ff;
               state_in = S_PROD_MULW;
            end else begin
               mul_a = v_ff;
               mul_b = e_ff;
               state_in = S_POW_MULW;
            end
         end
         S_POW_MULW: begin
            if (mul_done) begin
               v_in = mul_res;
               pow_in = pow_ff - 2'd1;
               state_in = S_POW_CHK;
            end
         end
         S_PROD_MULW: begin
            if (mul_done) begin
               f_in = {1'b0, mul_res} - {19'd0, target_ff};
               d_in = v_ff + mul_res;
               state_in = ret_ff;
            end
         end
         S_R_BLO: begin
            sl_in = sm;
            ex_x_in = hi_ff;
            ret_in = S_R_BHI;
            state_in = S_EV_START;
         end
         S_R_BHI: begin
            sh_in = sm;
            if (same_sign(sl_ff, sm)) begin
               status_in = ST_NOSIGN;
               root_in = '0;
               state_in = S_DONE;
            end else begin
               mid_in = X_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
               state_in = S_B_CHK;
            end
         end
         S_B_CHK: begin
            if ({23'd0, span} > {24'd0, tol_ff}) begin
               if (steps_ff >= MAX_STEPS) begin
                  status_in = ST_LIMIT;
                  root_in = mid_ff;
                  state_in = S_DONE;
               end else begin
                  mid_in = X_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
                  ex_x_in = X_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
                  ret_in = S_R_BMID;
                  state_in = S_EV_START;
               end
            end else begin
               root_in = mid_ff;
               state_in = S_DONE;
            end
         end
         S_R_BMID: begin
            // The end signs stay valid across steps, so only the midpoint is evaluated.
            if (opposite_sign(sl_ff, sm)) begin
               hi_in = mid_ff;
               sh_in = sm;
               steps_in = steps_ff + 7'd1;
               state_in = S_B_CHK;
            end else if (opposite_sign(sm, sh_ff)) begin
               lo_in = mid_ff;
               sl_in = sm;
               steps_in = steps_ff + 7'd1;
               state_in = S_B_CHK;
            end else begin
               status_in = ST_NOSIGN;
               root_in = mid_ff;
               state_in = S_DONE;
            end
         end
         S_R_NFIRST: begin
            if (d_ff == 64'd0) begin
               status_in = ST_ZERODERIV;
               root_in = x_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_N_CHK;
            end
         end
         S_N_CHK: begin
            if (dx_ff > {23'd0, tol_ff}) begin
               if (steps_ff >= MAX_STEPS) begin
                  status_in = ST_LIMIT;
                  root_in = x_ff;
                  state_in = S_DONE;
               end else begin
                  ex_x_in = x_ff;
                  ret_in = S_R_NEV;
                  state_in = S_EV_START;
               end
            end else begin
               root_in = x_ff;
               state_in = S_DONE;
            end
         end
         S_R_NEV: begin
            if (d_ff == 64'd0) begin
               status_in = ST_ZERODERIV;
               root_in = x_ff;
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               div_num = {fmag, 40'd0};
               div_den = d_ff;
               state_in = S_N_DIVW;
            end
         end
         S_N_DIVW: begin
            if (div_done) begin
               dx_in = (xn >= x_ff) ? {22'd0, xn - x_ff} : {22'd0, x_ff - xn};
               x_in = xn;
               steps_in = steps_ff + 7'd1;
               state_in = S_N_CHK;
            end
         end
         S_DONE: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         steps_ff <= '0;
         lo_ff    <= '0;
         hi_ff    <= '0;
         x_ff     <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         steps_ff <= steps_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         x_ff     <= x_in;
      end
      tol_ff <= tol_in; mid_ff <= mid_in; ex_x_ff <= ex_x_in; root_ff <= root_in;
      dx_ff <= dx_in; r_ff <= r_in; sum_ff <= sum_in; term_ff <= term_in;
      v_ff <= v_in; e_ff <= e_in; d_ff <= d_in; f_ff <= f_in; k_ff <= k_in;
      exp_sel_ff <= exp_sel_in; pow_ff <= pow_in; status_ff <= status_in;
      sl_ff <= sl_in; sh_ff <= sh_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata  = {7'd0, steps_ff, root_ff};
   assign rsp_tuser  = status_ff;

endmodule
`default_nettype wire
